// File: rtl/abld_pkg.sv
// Shared types and constants for the ambient light backlight dimmer.
// Used by abld_core, ambient_light_backlight_dimmer_top and abld_checker.
package abld_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 16;
	localparam int WEIGHT_BITS   = 16;
	localparam int DUTY_BITS     = 8;
	localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
	localparam int MUL_A_BITS    = WEIGHT_BITS + 1;
	localparam int MUL_B_BITS    = AVG_BITS;
	localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
	localparam int QUO_BITS      = SAMPLE_BITS + DUTY_BITS;
	localparam int DIV_STEPS     = QUO_BITS;
	localparam int CNT_BITS      = $clog2(DIV_STEPS);
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = WEIGHT_BITS;
	localparam int S_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS  = ((DUTY_BITS + SAMPLE_BITS + 7) / 8) * 8;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd3277;
	localparam logic [SAMPLE_BITS-1:0] DARK_RESET   = 12'd150;
	localparam logic [SAMPLE_BITS-1:0] BRIGHT_RESET = 12'd3600;
	localparam logic [DUTY_BITS-1:0]   MIN_RESET    = 8'd15;
	localparam logic [DUTY_BITS-1:0]   DUTY_MAX     = 8'd255;
	localparam logic [MUL_A_BITS-1:0]  WEIGHT_ONE   = 17'd65536;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WEIGHT = 2'd0,
		CFG_DARK   = 2'd1,
		CFG_BRIGHT = 2'd2,
		CFG_MIN    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] smoothing_weight;
		logic [SAMPLE_BITS-1:0] dark_level;
		logic [SAMPLE_BITS-1:0] bright_level;
		logic [DUTY_BITS-1:0]   min_duty;
	} cfg_t;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_MUL_NEW = 8'b0000_0010,
		ST_MUL_OLD = 8'b0000_0100,
		ST_SUM     = 8'b0000_1000,
		ST_MAP     = 8'b0001_0000,
		ST_MAP_MUL = 8'b0010_0000,
		ST_DIV     = 8'b0100_0000,
		ST_FIN     = 8'b1000_0000
	} state_t;

endpackage

// File: rtl/abld_core.sv
// Sequencer and datapath: filter update, linear map and clamp.
// One shared multiplier and a restoring divider; depends on abld_pkg.
module abld_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  abld_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [abld_pkg::SAMPLE_BITS-1:0]    in_sample,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [abld_pkg::DUTY_BITS-1:0]      res_duty,
	output logic [abld_pkg::SAMPLE_BITS-1:0]    res_level
);

	abld_pkg::state_t                      state_q;
	logic [abld_pkg::SAMPLE_BITS-1:0]      x_q;
	logic [abld_pkg::AVG_BITS-1:0]         avg_q;
	logic                                  seeded_q;
	logic [abld_pkg::AVG_BITS-1:0]         t1_q;
	logic [abld_pkg::PROD_BITS-1:0]        prod_q;
	logic [abld_pkg::SAMPLE_BITS-1:0]      mag_q;
	logic [abld_pkg::SAMPLE_BITS-1:0]      den_q;
	logic [abld_pkg::SAMPLE_BITS-1:0]      rem_q;
	logic                                  neg_q;
	logic                                  zero_q;
	logic [abld_pkg::CNT_BITS-1:0]         cnt_q;

	logic [abld_pkg::MUL_A_BITS-1:0]       mul_a;
	logic [abld_pkg::MUL_B_BITS-1:0]       mul_b;
	logic [abld_pkg::PROD_BITS-1:0]        mul_p;
	logic [abld_pkg::SAMPLE_BITS-1:0]      level;
	logic [abld_pkg::SAMPLE_BITS:0]        diff_a;
	logic [abld_pkg::SAMPLE_BITS:0]        diff_r;
	logic [abld_pkg::DUTY_BITS-1:0]        span;
	logic [abld_pkg::SAMPLE_BITS:0]        trial;
	logic [abld_pkg::SAMPLE_BITS:0]        trial_diff;
	logic                                  trial_ok;
	logic [abld_pkg::QUO_BITS-1:0]         quo;

	assign level  = avg_q[abld_pkg::AVG_BITS-1:abld_pkg::FRACTION_BITS];
	assign diff_a = {1'b0, level} - {1'b0, cfg.dark_level};
	assign diff_r = {1'b0, cfg.bright_level} - {1'b0, cfg.dark_level};
	assign span   = abld_pkg::DUTY_MAX - cfg.min_duty;

	always_comb begin
		unique case (state_q)
			abld_pkg::ST_MUL_OLD: begin
				mul_a = abld_pkg::WEIGHT_ONE - {1'b0, cfg.smoothing_weight};
				mul_b = avg_q;
			end
			abld_pkg::ST_MAP_MUL: begin
				mul_a = abld_pkg::MUL_A_BITS'(span);
				mul_b = abld_pkg::MUL_B_BITS'(mag_q);
			end
			default: begin
				mul_a = abld_pkg::MUL_A_BITS'(cfg.smoothing_weight);
				mul_b = abld_pkg::MUL_B_BITS'(x_q);
			end
		endcase
	end

	assign mul_p = abld_pkg::PROD_BITS'(mul_a) * abld_pkg::PROD_BITS'(mul_b);

	assign trial      = {rem_q, prod_q[abld_pkg::QUO_BITS-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign trial_ok   = !trial_diff[abld_pkg::SAMPLE_BITS];
	assign quo        = prod_q[abld_pkg::QUO_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= abld_pkg::ST_IDLE;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				abld_pkg::ST_IDLE: begin
					if (in_valid) begin
						seeded_q <= 1'b1;
						state_q  <= abld_pkg::ST_MUL_NEW;
					end
				end
				abld_pkg::ST_MUL_NEW: state_q <= abld_pkg::ST_MUL_OLD;
				abld_pkg::ST_MUL_OLD: state_q <= abld_pkg::ST_SUM;
				abld_pkg::ST_SUM:     state_q <= abld_pkg::ST_MAP;
				abld_pkg::ST_MAP:     state_q <= abld_pkg::ST_MAP_MUL;
				abld_pkg::ST_MAP_MUL: begin
					cnt_q   <= '0;
					state_q <= abld_pkg::ST_DIV;
				end
				abld_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == abld_pkg::CNT_BITS'(abld_pkg::DIV_STEPS - 1)) begin
						state_q <= abld_pkg::ST_FIN;
					end
				end
				abld_pkg::ST_FIN: begin
					if (res_ready) begin
						state_q <= abld_pkg::ST_IDLE;
					end
				end
				default: state_q <= abld_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			abld_pkg::ST_IDLE: begin
				if (in_valid) begin
					x_q <= in_sample;
					if (!seeded_q) begin
						avg_q <= {in_sample, abld_pkg::FRACTION_BITS'(0)};
					end
				end
			end
			abld_pkg::ST_MUL_NEW: prod_q <= mul_p;
			abld_pkg::ST_MUL_OLD: begin
				t1_q   <= prod_q[abld_pkg::AVG_BITS-1:0];
				prod_q <= mul_p;
			end
			abld_pkg::ST_SUM: begin
				avg_q <= t1_q + prod_q[abld_pkg::WEIGHT_BITS +: abld_pkg::AVG_BITS];
			end
			abld_pkg::ST_MAP: begin
				mag_q  <= diff_a[abld_pkg::SAMPLE_BITS] ?
					abld_pkg::SAMPLE_BITS'(-diff_a) : diff_a[abld_pkg::SAMPLE_BITS-1:0];
				den_q  <= diff_r[abld_pkg::SAMPLE_BITS] ?
					abld_pkg::SAMPLE_BITS'(-diff_r) : diff_r[abld_pkg::SAMPLE_BITS-1:0];
				neg_q  <= diff_a[abld_pkg::SAMPLE_BITS] == diff_r[abld_pkg::SAMPLE_BITS];
				zero_q <= diff_r == '0;
			end
			abld_pkg::ST_MAP_MUL: begin
				prod_q <= mul_p;
				rem_q  <= '0;
			end
			abld_pkg::ST_DIV: begin
				rem_q <= trial_ok ? trial_diff[abld_pkg::SAMPLE_BITS-1:0]
					: trial[abld_pkg::SAMPLE_BITS-1:0];
				prod_q[abld_pkg::QUO_BITS-1:0] <= {quo[abld_pkg::QUO_BITS-2:0], trial_ok};
			end
			default: ;
		endcase
	end

	always_comb begin
		priority if (zero_q) begin
			res_duty = cfg.min_duty;
		end else if (!neg_q) begin
			res_duty = abld_pkg::DUTY_MAX;
		end else if (quo > abld_pkg::QUO_BITS'(span)) begin
			res_duty = cfg.min_duty;
		end else begin
			res_duty = abld_pkg::DUTY_MAX - quo[abld_pkg::DUTY_BITS-1:0];
		end
	end

	assign in_ready  = state_q == abld_pkg::ST_IDLE;
	assign res_valid = state_q == abld_pkg::ST_FIN;
	assign res_level = level;

endmodule

// File: rtl/ambient_light_backlight_dimmer_top.sv
// Top level of the ambient light backlight dimmer: ports, registers, result stage.
// Depends on abld_pkg and abld_core.
//
// Usage:
//   s_* carries one 12-bit light sensor sample per item; m_* returns one item
//   per sample with the PWM duty and the integer part of the moving average.
//   cfg_* writes the weight, dark level, bright level and duty floor; write
//   only while no sample is in flight. cfg_ready is always high.
// Timing:
//   From acceptance to its result entering the output register, a sample
//   makes three passes through the shared multiplier for the filter
//   update and the map product, goes through the sum and map bookkeeping
//   states, a 20-step restoring divider for the map quotient and the
//   finish state handing the result over. s_tready stays low while a
//   sample is in work, so no new sample is taken until the core is idle.
// Reset:
//   Configuration registers return to their default values and the filter is unseeded:
//   the first sample after reset sets the average.
// Stall:
//   A finished result waits in the output register; the next sample is
//   taken meanwhile and its own result waits in the core until the register
//   frees.
module ambient_light_backlight_dimmer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [abld_pkg::S_TDATA_BITS-1:0]    s_tdata,   // [11:0] adc_sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [abld_pkg::M_TDATA_BITS-1:0]    m_tdata,   // [7:0] duty, [19:8] filtered_level
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [abld_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [abld_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	abld_pkg::cfg_t                      cfg_q;
	logic                                m_valid_q;
	logic [abld_pkg::DUTY_BITS-1:0]      duty_q;
	logic [abld_pkg::SAMPLE_BITS-1:0]    level_q;
	logic                                res_valid;
	logic                                res_ready;
	logic [abld_pkg::DUTY_BITS-1:0]      res_duty;
	logic [abld_pkg::SAMPLE_BITS-1:0]    res_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_weight <= abld_pkg::WEIGHT_RESET;
			cfg_q.dark_level       <= abld_pkg::DARK_RESET;
			cfg_q.bright_level     <= abld_pkg::BRIGHT_RESET;
			cfg_q.min_duty         <= abld_pkg::MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (abld_pkg::cfg_idx_t'(cfg_index))
				abld_pkg::CFG_WEIGHT: cfg_q.smoothing_weight <= cfg_data;
				abld_pkg::CFG_DARK:   cfg_q.dark_level <= cfg_data[abld_pkg::SAMPLE_BITS-1:0];
				abld_pkg::CFG_BRIGHT: cfg_q.bright_level <= cfg_data[abld_pkg::SAMPLE_BITS-1:0];
				abld_pkg::CFG_MIN:    cfg_q.min_duty <= cfg_data[abld_pkg::DUTY_BITS-1:0];
				default: ;
			endcase
		end
	end

	abld_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[abld_pkg::SAMPLE_BITS-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_duty  (res_duty),
		.res_level (res_level)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			duty_q  <= res_duty;
			level_q <= res_level;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = abld_pkg::M_TDATA_BITS'({level_q, duty_q});

endmodule

// File: rtl/abld_checker.sv
// Port-level checks for the ambient light backlight dimmer, bound to the top level.
// Depends on abld_pkg.
module abld_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [abld_pkg::S_TDATA_BITS-1:0]    s_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [abld_pkg::M_TDATA_BITS-1:0]    m_tdata,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [abld_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [abld_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int PAD_LSB = abld_pkg::DUTY_BITS + abld_pkg::SAMPLE_BITS;

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken again while an item is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without the core being busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[abld_pkg::M_TDATA_BITS-1:PAD_LSB] == '0)
		else $error("output padding not zero");

endmodule

bind ambient_light_backlight_dimmer_top abld_checker u_abld_checker (.*);

// File: tb/ambient_light_backlight_dimmer_top_tb.sv
// Self-checking testbench for the ambient light backlight dimmer: directed and random
// samples under several register settings, checked against an in-bench filter and map model.
// Depends on abld_pkg and ambient_light_backlight_dimmer_top.
module ambient_light_backlight_dimmer_top_tb;
	import abld_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RAND_PHASES    = 7;
	localparam int PHASE_ITEMS    = 205;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] level;
		logic [DUTY_BITS-1:0]   duty;
	} dimmer_out_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [S_TDATA_BITS-1:0]  s_tdata   = '0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [M_TDATA_BITS-1:0]  m_tdata;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_WEIGHT;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	logic [SAMPLE_BITS-1:0] queued_samples[$];
	dimmer_out_t            pending_results[$];

	logic [WEIGHT_BITS-1:0] weight_q  = WEIGHT_RESET;
	logic [SAMPLE_BITS-1:0] dark_q    = DARK_RESET;
	logic [SAMPLE_BITS-1:0] bright_q  = BRIGHT_RESET;
	logic [DUTY_BITS-1:0]   floor_q   = MIN_RESET;
	logic [AVG_BITS-1:0]    avg_fx    = '0;
	bit                     filter_seeded = 1'b0;

	bit idle_en        = 1'b1;
	int stall_req      = 0;
	int stall_ack      = 0;
	int stall_left     = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	ambient_light_backlight_dimmer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [11:0] adc_sample
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] duty, [19:8] filtered_level
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic dimmer_out_t predict_dimmer_output(input logic [SAMPLE_BITS-1:0] sample);
		longint unsigned new_part;
		longint unsigned old_part;
		longint          lvl, dk, br, mn, span, duty_v;
		dimmer_out_t     r;
		if (!filter_seeded) begin
			avg_fx = {sample, {FRACTION_BITS{1'b0}}};
			filter_seeded = 1'b1;
		end
		new_part = weight_q;
		new_part = (new_part * sample) << (FRACTION_BITS - WEIGHT_BITS);
		old_part = WEIGHT_ONE - weight_q;
		old_part = (old_part * avg_fx) >> WEIGHT_BITS;
		avg_fx = AVG_BITS'(new_part + old_part);
		r.level = avg_fx[AVG_BITS-1 -: SAMPLE_BITS];
		lvl = r.level;
		dk = dark_q;
		br = bright_q;
		mn = floor_q;
		span = br - dk;
		if (span == 0) begin
			duty_v = -1;
		end else begin
			duty_v = (lvl - dk) * (mn - 255) / span + 255;
		end
		if (duty_v < mn) begin
			duty_v = mn;
		end else if (duty_v > 255) begin
			duty_v = 255;
		end
		r.duty = duty_v[DUTY_BITS-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(predict_dimmer_output(s_tdata[SAMPLE_BITS-1:0]));
			end
			if (!s_tvalid || s_tready) begin
				if (queued_samples.size() != 0 && !(idle_en && $urandom_range(99) < 11)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= S_TDATA_BITS'(queued_samples.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		dimmer_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[7:0] !== want.duty) begin
						report_mismatch($sformatf("duty %0d, expected %0d",
							m_tdata[7:0], want.duty));
					end
					if (m_tdata[19:8] !== want.level) begin
						report_mismatch($sformatf("filtered_level %0d, expected %0d",
							m_tdata[19:8], want.level));
					end
				end
			end
			if (stall_req != stall_ack) begin
				stall_ack = stall_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_en && $urandom_range(99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ambient_light_backlight_dimmer_top_tb failed");
				$finish;
			end
		end
	end

	task automatic write_settings(input logic [WEIGHT_BITS-1:0] w, input logic [SAMPLE_BITS-1:0] dk,
			input logic [SAMPLE_BITS-1:0] br, input logic [DUTY_BITS-1:0] mn);
		cfg_idx_t                 idx;
		logic [CFG_DATA_BITS-1:0] val;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			case (idx)
				CFG_WEIGHT: val = w;
				CFG_DARK:   val = CFG_DATA_BITS'(dk);
				CFG_BRIGHT: val = CFG_DATA_BITS'(br);
				default:    val = CFG_DATA_BITS'(mn);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx)
				CFG_WEIGHT: weight_q = w;
				CFG_DARK:   dark_q = dk;
				CFG_BRIGHT: bright_q = br;
				default:    floor_q = mn;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (queued_samples.size() != 0 || s_tvalid || pending_results.size() != 0);
	endtask

	initial begin
		logic [WEIGHT_BITS-1:0] w;
		logic [SAMPLE_BITS-1:0] dk, br, s;
		logic [DUTY_BITS-1:0]   mn;
		int                     pick, lo, hi;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seed, extremes, alternating bits, the reset dark and bright levels
		queued_samples = '{12'hFFF, 12'h000, 12'hFFF, 12'h555, 12'hAAA,
			12'd150, 12'd3600, 12'h800};
		drain();
		write_settings(16'hFFFF, 12'd0, 12'hFFF, 8'd0);
		queued_samples = '{12'h000, 12'hFFF, 12'h001, 12'hFFE};
		drain();
		// weight zero: hold the average
		write_settings(16'h0000, 12'd150, 12'd3600, 8'd15);
		queued_samples = '{12'h000, 12'hFFF, 12'h800};
		drain();
		// equal dark and bright
		write_settings(16'h0001, 12'd2000, 12'd2000, 8'd200);
		queued_samples = '{12'hFFF, 12'h000, 12'd2000};
		drain();
		// dark above bright
		write_settings(16'h8000, 12'hFFF, 12'd0, 8'hFF);
		queued_samples = '{12'h000, 12'hFFF, 12'd1000};
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(5))
				0: w = 16'hFFFF;
				1: w = 16'h0001;
				2: w = 16'($urandom_range(1, 65535));
				3: w = 16'($urandom_range(1, 4096));
				4: w = 16'($urandom_range(16384, 65535));
				default: w = 16'h0000;
			endcase
			dk = 12'($urandom_range(4095));
			case ($urandom_range(4))
				0: br = 12'($urandom_range(4095));
				1: br = dk;
				2: begin
					dk = 12'd0;
					br = 12'hFFF;
				end
				3: begin
					dk = 12'hFFF;
					br = 12'd0;
				end
				default: br = dk ^ 12'($urandom_range(1, 15));
			endcase
			case ($urandom_range(2))
				0: mn = 8'd0;
				1: mn = 8'hFF;
				default: mn = 8'($urandom_range(255));
			endcase
			write_settings(w, dk, br, mn);
			idle_en = !(p == 2 || p == 5);
			if (p == 2) begin
				stall_req++;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					s = 12'($urandom_range(4095));
				end else if (pick < 75) begin
					s = $urandom_range(1) ? 12'hFFF : 12'h000;
				end else begin
					lo = $urandom_range(1) ? int'(dark_q) : int'(bright_q);
					hi = lo + $urandom_range(32) - 16;
					s = (hi < 0) ? 12'd0 : (hi > 4095) ? 12'hFFF : 12'(hi);
				end
				queued_samples.push_back(s);
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("ambient_light_backlight_dimmer_top_tb passed");
		end else begin
			$display("ambient_light_backlight_dimmer_top_tb failed");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/abld_pkg.sv
rtl/abld_core.sv
rtl/ambient_light_backlight_dimmer_top.sv
rtl/abld_checker.sv
tb/ambient_light_backlight_dimmer_top_tb.sv
